/* rtl/core/bzr_pkg.sv */
// Shared constants and types for the cubic Bezier point evaluator.
// No dependencies; every other file of the block but bzr_if imports this package.
package bzr_pkg;

  // Register file layout: one register per control point coordinate.
  localparam int NUM_REGS  = 8;
  localparam int IDX_BITS  = 3;
  localparam int ADDR_BITS = IDX_BITS + 2;
  localparam int DATA_BITS = 32;

  localparam logic [IDX_BITS-1:0] REG_P0_X = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_P0_Y = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_P1_X = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_P1_Y = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_P2_X = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_P2_Y = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_P3_X = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_P3_Y = 3'd7;

  // Load enables for the two register stages of one interpolation level.
  typedef struct packed {
    logic en_mul;
    logic en_add;
  } lerp_ctrl_t;

endpackage

/* rtl/core/bzr_if.sv */
// Valid/ready stream interfaces for curve parameters and curve points.
// Uses no package; widths come from interface parameters.
interface bzr_param_if #(
  parameter int T_BITS = 11
);
  logic              valid;
  logic              ready;
  logic [T_BITS-1:0] t_param;

  modport source (output valid, output t_param, input ready);
  modport sink   (input valid, input t_param, output ready);
endinterface

interface bzr_point_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

/* rtl/core/cubic_bezier_point_eval.sv */
// Cubic Bezier point evaluator, top level: register file and seven-stage datapath.
// Depends on bzr_pkg, the interfaces in bzr_if, bzr_cfg_regs and bzr_lerp_level.
//
// Evaluates a cubic Bezier curve by de Casteljau's method. The four control
// points are written through the APB port (p0_x at 0x00 up to p3_y at 0x1C) and
// should be changed only while no word is in flight. Each parameter word
// carries t in unsigned Q1.FRAC_BITS, where 1 << FRAC_BITS is 1.0 and larger
// values are clamped to 1.0; each gives one point word with the curve point
// truncated to whole pixels. The pipeline takes one word per cycle while the
// output is not stalled and has seven register stages: one stage clamps t, then
// each of the three interpolation levels spends one stage on a multiplier and
// one on the add. A stalled output holds the pipeline only where it is full, so
// bubbles are squeezed out while the result waits.
module cubic_bezier_point_eval
  import bzr_pkg::*;
#(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  bzr_param_if.sink            param_ch,
  bzr_point_if.source          point_ch
);

  localparam int W      = COORD_BITS + FRAC_BITS;
  localparam int STAGES = 7;
  localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [3:0][COORD_BITS-1:0] ctrl_x;
  logic [3:0][COORD_BITS-1:0] ctrl_y;

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   en;

  logic [FRAC_BITS:0]    t_reg;
  logic [FRAC_BITS:0]    t_l1;
  logic [FRAC_BITS:0]    t_l2;
  logic [FRAC_BITS:0]    t_l3;
  logic [3:0][W-1:0]     a_x;
  logic [3:0][W-1:0]     a_y;
  logic [2:0][W-1:0]     b_x;
  logic [2:0][W-1:0]     b_y;
  logic [1:0][W-1:0]     d_x;
  logic [1:0][W-1:0]     d_y;
  logic [0:0][W-1:0]     e_x;
  logic [0:0][W-1:0]     e_y;
  lerp_ctrl_t            ctrl_l1;
  lerp_ctrl_t            ctrl_l2;
  lerp_ctrl_t            ctrl_l3;

  bzr_cfg_regs #(
    .COORD_BITS(COORD_BITS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctrl_x  (ctrl_x),
    .ctrl_y  (ctrl_y)
  );

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    en[STAGES] = point_ch.ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign param_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= param_ch.valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Input stage: clamp t to one.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_reg <= (param_ch.t_param > T_ONE) ? T_ONE : param_ch.t_param;
    end
  end

  // Control points widened to fixed point.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a_x[i] = {ctrl_x[i], {FRAC_BITS{1'b0}}};
      a_y[i] = {ctrl_y[i], {FRAC_BITS{1'b0}}};
    end
  end

  assign ctrl_l1 = '{en_mul: en[1], en_add: en[2]};
  assign ctrl_l2 = '{en_mul: en[3], en_add: en[4]};
  assign ctrl_l3 = '{en_mul: en[5], en_add: en[6]};

  bzr_lerp_level #(
    .LANES(3), .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)
  ) u_level1 (
    .clk(clk), .ctrl(ctrl_l1), .t_in(t_reg), .pts_x(a_x), .pts_y(a_y),
    .t_out(t_l1), .res_x(b_x), .res_y(b_y)
  );

  bzr_lerp_level #(
    .LANES(2), .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)
  ) u_level2 (
    .clk(clk), .ctrl(ctrl_l2), .t_in(t_l1), .pts_x(b_x), .pts_y(b_y),
    .t_out(t_l2), .res_x(d_x), .res_y(d_y)
  );

  bzr_lerp_level #(
    .LANES(1), .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)
  ) u_level3 (
    .clk(clk), .ctrl(ctrl_l3), .t_in(t_l2), .pts_x(d_x), .pts_y(d_y),
    .t_out(t_l3), .res_x(e_x), .res_y(e_y)
  );

  // The last stage register doubles as the output register; t is dropped here.
  assign point_ch.valid   = vld[STAGES-1] & (t_l3 == t_l3);
  assign point_ch.pixel_x = e_x[0][W-1:FRAC_BITS];
  assign point_ch.pixel_y = e_y[0][W-1:FRAC_BITS];

endmodule

/* rtl/core/bzr_cfg_regs.sv */
// APB-style register file holding the four control points.
// Depends on bzr_pkg for the register map and bus widths.
module bzr_cfg_regs
  import bzr_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ADDR_BITS-1:0]           paddr,
  input  logic [DATA_BITS-1:0]           pwdata,
  output logic [DATA_BITS-1:0]           prdata,
  output logic                           pready,
  output logic [3:0][COORD_BITS-1:0]     ctrl_x,
  output logic [3:0][COORD_BITS-1:0]     ctrl_y
);

  logic [COORD_BITS-1:0] regs [NUM_REGS];
  logic [IDX_BITS-1:0]   idx;

  assign idx    = paddr[ADDR_BITS-1:2];
  assign pready = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      regs[idx] <= pwdata[COORD_BITS-1:0];
    end
  end

  // Read data is the addressed register, zero extended.
  always_comb begin
    prdata = {{(DATA_BITS-COORD_BITS){1'b0}}, regs[idx]};
  end

  // Control points as seen by the datapath.
  assign ctrl_x[0] = regs[REG_P0_X];
  assign ctrl_y[0] = regs[REG_P0_Y];
  assign ctrl_x[1] = regs[REG_P1_X];
  assign ctrl_y[1] = regs[REG_P1_Y];
  assign ctrl_x[2] = regs[REG_P2_X];
  assign ctrl_y[2] = regs[REG_P2_Y];
  assign ctrl_x[3] = regs[REG_P3_X];
  assign ctrl_y[3] = regs[REG_P3_Y];

endmodule

/* rtl/core/bzr_lerp_level.sv */
// One de Casteljau level: LANES fixed-point lerps per axis in two stages.
// Depends on bzr_pkg for the stage control struct.
module bzr_lerp_level
  import bzr_pkg::*;
#(
  parameter int LANES      = 3,
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 10
) (
  input  logic                                      clk,
  input  lerp_ctrl_t                                ctrl,
  input  logic [FRAC_BITS:0]                        t_in,
  input  logic [LANES:0][COORD_BITS+FRAC_BITS-1:0]   pts_x,
  input  logic [LANES:0][COORD_BITS+FRAC_BITS-1:0]   pts_y,
  output logic [FRAC_BITS:0]                        t_out,
  output logic [LANES-1:0][COORD_BITS+FRAC_BITS-1:0] res_x,
  output logic [LANES-1:0][COORD_BITS+FRAC_BITS-1:0] res_y
);

  localparam int W  = COORD_BITS + FRAC_BITS;
  localparam int PW = W + FRAC_BITS + 3;

  logic signed [PW-1:0] prod_x [LANES];
  logic signed [PW-1:0] prod_y [LANES];
  logic signed [PW-1:0] prod_x_next [LANES];
  logic signed [PW-1:0] prod_y_next [LANES];
  logic [W-1:0]         base_x [LANES];
  logic [W-1:0]         base_y [LANES];
  logic [FRAC_BITS:0]   t_mid;
  logic signed [PW-1:0] t_ext;

  assign t_ext = $signed({{(PW-FRAC_BITS-1){1'b0}}, t_in});

  // Product stage: (b - a) * t, signed so the later shift floors.
  always_comb begin
    logic signed [W:0] dx;
    logic signed [W:0] dy;
    for (int i = 0; i < LANES; i++) begin
      dx = $signed({1'b0, pts_x[i+1]}) - $signed({1'b0, pts_x[i]});
      dy = $signed({1'b0, pts_y[i+1]}) - $signed({1'b0, pts_y[i]});
      prod_x_next[i] = $signed({{(PW-W-1){dx[W]}}, dx}) * t_ext;
      prod_y_next[i] = $signed({{(PW-W-1){dy[W]}}, dy}) * t_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_mul) begin
      for (int i = 0; i < LANES; i++) begin
        prod_x[i] <= prod_x_next[i];
        prod_y[i] <= prod_y_next[i];
        base_x[i] <= pts_x[i];
        base_y[i] <= pts_y[i];
      end
      t_mid <= t_in;
    end
  end

  // Sum stage: a + floor(product / ONE); the result stays within a and b.
  always_ff @(posedge clk) begin
    logic signed [PW-1:0] sx;
    logic signed [PW-1:0] sy;
    if (ctrl.en_add) begin
      for (int i = 0; i < LANES; i++) begin
        sx = $signed({{(PW-W){1'b0}}, base_x[i]}) + (prod_x[i] >>> FRAC_BITS);
        sy = $signed({{(PW-W){1'b0}}, base_y[i]}) + (prod_y[i] >>> FRAC_BITS);
        res_x[i] <= sx[W-1:0];
        res_y[i] <= sy[W-1:0];
      end
      t_out <= t_mid;
    end
  end

endmodule

/* tb/sv/cubic_bezier_point_eval_tb.sv */
// Testbench for cubic_bezier_point_eval: directed t sweeps, then random phases.
// Each phase loads new control points over APB, streams t words and checks each point.
// Depends on bzr_pkg, the stream interfaces in bzr_if and the block's RTL.
`timescale 1ns / 100ps

module cubic_bezier_point_eval_tb;
  import bzr_pkg::*;

  localparam int COORD_W      = 10;
  localparam int FRAC_W       = 10;
  localparam int T_W          = 11;
  localparam int PIPE_LATENCY = 7;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_WORDS  = 113;
  localparam int LONG_HOLD    = 80;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_W;

  typedef logic [COORD_W-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // One directed row: control point set, t, and an optional typed-in point.
  typedef struct packed {
    logic [1:0]     set_id;
    logic [T_W-1:0] t;
    logic           typed;
    coord_t         ex;
    coord_t         ey;
  } sweep_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  bzr_param_if #(.T_BITS(T_W))          param_ch ();
  bzr_point_if #(.COORD_BITS(COORD_W))  point_ch ();

  cubic_bezier_point_eval #(
    .COORD_BITS(COORD_W),
    .FRAC_BITS (FRAC_W)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .param_ch(param_ch),
    .point_ch(point_ch)
  );

  // Shadow of the control point registers and the points still owed.
  coord_t ctrl_regs [NUM_REGS];
  int     staged_points [NUM_REGS];
  point_t expected_points [$];

  int mismatches = 0;
  int points_checked = 0;
  int words_sent = 0;
  int sets_loaded = 0;
  int send_gap_max = 13;
  int recv_gap_max = 13;
  bit long_hold_pending = 1'b0;

  // Control point sets for the directed sweep: reset values, alternating
  // extremes, and every coordinate at its maximum.
  int point_sets [3][NUM_REGS] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{1023, 0, 0, 1023, 1023, 0, 0, 1023},
    '{1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023}
  };

  // Rows with a typed point are the reset state, t at zero or at one and above,
  // and a degenerate curve; the rest go through the predictor.
  sweep_row_t sweep_rows [21] = '{
    '{2'd0, 11'd0,    1'b1, 10'd0,    10'd0},
    '{2'd0, 11'd1024, 1'b1, 10'd0,    10'd0},
    '{2'd0, 11'd2047, 1'b1, 10'd0,    10'd0},
    '{2'd1, 11'd0,    1'b1, 10'd1023, 10'd0},
    '{2'd1, 11'd1,    1'b0, 10'd0,    10'd0},
    '{2'd1, 11'd2,    1'b0, 10'd0,    10'd0},
    '{2'd1, 11'd341,  1'b0, 10'd0,    10'd0},
    '{2'd1, 11'd512,  1'b0, 10'd0,    10'd0},
    '{2'd1, 11'd683,  1'b0, 10'd0,    10'd0},
    '{2'd1, 11'd1022, 1'b0, 10'd0,    10'd0},
    '{2'd1, 11'd1023, 1'b0, 10'd0,    10'd0},
    '{2'd1, 11'd1024, 1'b1, 10'd0,    10'd1023},
    '{2'd1, 11'd1025, 1'b1, 10'd0,    10'd1023},
    '{2'd1, 11'd1536, 1'b1, 10'd0,    10'd1023},
    '{2'd1, 11'd2047, 1'b1, 10'd0,    10'd1023},
    '{2'd1, 11'd1365, 1'b1, 10'd0,    10'd1023},
    '{2'd2, 11'd0,    1'b1, 10'd1023, 10'd1023},
    '{2'd2, 11'd777,  1'b1, 10'd1023, 10'd1023},
    '{2'd2, 11'd1023, 1'b1, 10'd1023, 10'd1023},
    '{2'd2, 11'd1024, 1'b1, 10'd1023, 10'd1023},
    '{2'd2, 11'd2047, 1'b1, 10'd1023, 10'd1023}
  };

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stream inputs start at known values.
  initial begin
    param_ch.valid   = 1'b0;
    param_ch.t_param = '0;
    point_ch.ready   = 1'b0;
  end

  // One fixed-point lerp with FRAC_W fraction bits, rounded toward zero.
  function automatic logic [63:0] interp_fixed(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] t);
    return ((ONE_Q - t) * a + t * b) >> FRAC_W;
  endfunction

  // De Casteljau on one axis: three lerp levels, then truncation to a pixel.
  function automatic coord_t curve_axis(coord_t c0, coord_t c1, coord_t c2, coord_t c3,
                                        logic [T_W-1:0] t_in);
    logic [63:0] t;
    logic [63:0] b0, b1, b2, d0, d1, e;
    t  = (t_in > ONE_Q) ? ONE_Q : 64'(t_in);
    b0 = interp_fixed(64'(c0) << FRAC_W, 64'(c1) << FRAC_W, t);
    b1 = interp_fixed(64'(c1) << FRAC_W, 64'(c2) << FRAC_W, t);
    b2 = interp_fixed(64'(c2) << FRAC_W, 64'(c3) << FRAC_W, t);
    d0 = interp_fixed(b0, b1, t);
    d1 = interp_fixed(b1, b2, t);
    e  = interp_fixed(d0, d1, t);
    return coord_t'(e >> FRAC_W);
  endfunction

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input bit is_write, input int idx,
                            input logic [DATA_BITS-1:0] wdata,
                            output logic [DATA_BITS-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ADDR_BITS'(idx << 2);
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (is_write) ctrl_regs[idx] = wdata[COORD_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the staged control points with junk above the register width,
  // then reads every register back.
  task automatic load_points();
    logic [DATA_BITS-1:0] junk;
    logic [DATA_BITS-1:0] rdata;
    for (int i = 0; i < NUM_REGS; i++) begin
      junk = $urandom() & ~((DATA_BITS'(1) << COORD_W) - 1);
      apb_access(1'b1, i, junk | DATA_BITS'(staged_points[i]), rdata);
    end
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_access(1'b0, i, '0, rdata);
      if (rdata !== DATA_BITS'(ctrl_regs[i])) begin
        $display("%0t: register %0d readback, expected %0d, actual %0d",
                 $time, i, ctrl_regs[i], rdata);
        mismatches++;
      end
    end
    sets_loaded++;
  endtask

  // Offers one t word after a random gap; the owed point is queued on acceptance.
  task automatic send_param(input logic [T_W-1:0] t, input bit typed, input point_t typed_pt);
    int     gap;
    point_t pt;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      param_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    param_ch.valid   <= 1'b1;
    param_ch.t_param <= t;
    do @(posedge clk); while (!param_ch.ready);
    if (typed) begin
      pt = typed_pt;
    end else begin
      pt.x = curve_axis(ctrl_regs[REG_P0_X], ctrl_regs[REG_P1_X],
                        ctrl_regs[REG_P2_X], ctrl_regs[REG_P3_X], t);
      pt.y = curve_axis(ctrl_regs[REG_P0_Y], ctrl_regs[REG_P1_Y],
                        ctrl_regs[REG_P2_Y], ctrl_regs[REG_P3_Y], t);
    end
    expected_points.insert(expected_points.size(), pt);
    words_sent++;
  endtask

  // Lowers valid, then waits until every owed point has come back.
  task automatic drain_points();
    @(negedge clk);
    param_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
  endtask

  // Point receiver: random stall before each word, one long hold on request.
  initial begin
    int     stall;
    point_t want;
    forever begin
      stall = $urandom_range(0, recv_gap_max);
      if (long_hold_pending) begin
        stall = LONG_HOLD;
        long_hold_pending = 1'b0;
      end
      if (stall > 0) begin
        @(negedge clk);
        point_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      point_ch.ready <= 1'b1;
      do @(posedge clk); while (!point_ch.valid);
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point word, expected none, actual x=%0d y=%0d",
                 $time, point_ch.pixel_x, point_ch.pixel_y);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (point_ch.pixel_x !== want.x) begin
          $display("%0t: pixel_x mismatch, expected %0d, actual %0d",
                   $time, want.x, point_ch.pixel_x);
          mismatches++;
        end
        if (point_ch.pixel_y !== want.y) begin
          $display("%0t: pixel_y mismatch, expected %0d, actual %0d",
                   $time, want.y, point_ch.pixel_y);
          mismatches++;
        end
        points_checked++;
      end
    end
  end

  // Main sequence: reset, directed sweep, random phases, final drain.
  initial begin
    int             cur_set;
    int             sel;
    logic [T_W-1:0] t;
    point_t         typed_pt;

    for (int i = 0; i < NUM_REGS; i++) ctrl_regs[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sweep; a new control point set is loaded once the pipe is empty.
    cur_set = 0;
    foreach (sweep_rows[r]) begin
      if (int'(sweep_rows[r].set_id) != cur_set) begin
        drain_points();
        cur_set = sweep_rows[r].set_id;
        staged_points = point_sets[cur_set];
        load_points();
      end
      typed_pt.x = sweep_rows[r].ex;
      typed_pt.y = sweep_rows[r].ey;
      send_param(sweep_rows[r].t, sweep_rows[r].typed, typed_pt);
    end
    drain_points();

    // Random phases: fresh control points, mixed idling on both sides.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        case ($urandom_range(0, 3))
          0: staged_points[i] = 0;
          1: staged_points[i] = 1023;
          default: staged_points[i] = $urandom_range(0, 1023);
        endcase
      end
      load_points();
      send_gap_max = (ph % 3 == 0) ? 0 : 13;
      recv_gap_max = (ph % 4 == 1) ? 0 : 13;
      // Back-to-back input against a stalled output fills the pipeline.
      if (ph == 3 || ph == 6) begin
        send_gap_max = 0;
        long_hold_pending = 1'b1;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        sel = $urandom_range(0, 15);
        case (sel)
          0: t = '0;
          1: t = T_W'(ONE_Q);
          2: t = T_W'($urandom_range(1025, 2047));
          default: t = T_W'($urandom_range(0, 1024));
        endcase
        send_param(t, 1'b0, typed_pt);
      end
      drain_points();
    end

    repeat (4 * PIPE_LATENCY) @(posedge clk);
    $display("Checked %0d curve points from %0d t words over %0d control point loads,",
             points_checked, words_sent, sets_loaded);
    $display("including t at zero, at one and past one, and stalls on both streams.");
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
